FILE: rtl/bse_pkg.sv
package bse_pkg;

  localparam int COORD_W = 10;
  localparam int ITER_W  = 10;
  localparam int VAL_W   = 32;
  localparam int STEP_W  = 31;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IM  = 3'd6;

  // reset values of the configuration registers
  localparam logic signed [VAL_W-1:0] RST_ORIGIN_RE = -32'sd50331648;
  localparam logic signed [VAL_W-1:0] RST_ORIGIN_IM = -32'sd33554432;
  localparam logic [STEP_W-1:0]       RST_STEP_RE   = 31'd125829;
  localparam logic [STEP_W-1:0]       RST_STEP_IM   = 31'd83886;
  localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 10'd42;
  localparam logic signed [VAL_W-1:0] RST_START_RE  = 32'sd0;
  localparam logic signed [VAL_W-1:0] RST_START_IM  = 32'sd0;

  // hand-off queue between mapping front and iteration engine
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] col_out;
    logic [COORD_W-1:0] row_out;
    logic [ITER_W-1:0]  iter_count;
  } res_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] origin_re;
    logic signed [VAL_W-1:0] origin_im;
    logic [STEP_W-1:0]       step_re;
    logic [STEP_W-1:0]       step_im;
    logic [ITER_W-1:0]       max_iter;
    logic signed [VAL_W-1:0] start_re;
    logic signed [VAL_W-1:0] start_im;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic signed [VAL_W-1:0] cr;
    logic signed [VAL_W-1:0] ci;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_MUL,
    S_UPD,
    S_DONE
  } core_state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return VAL_W'(hi);
    end else if (v < lo) begin
      return VAL_W'(lo);
    end
    return VAL_W'(v);
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
    logic [VAL_W:0] neg;
    neg = -{v[VAL_W-1], v};
    if (v[VAL_W-1]) begin
      return neg[VAL_W-1:0];
    end
    return VAL_W'(v);
  endfunction

endpackage

FILE: rtl/bse_front.sv
module bse_front import bse_pkg::*; #(
  parameter int COORD_WIDTH = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  input  q_stat_t q_stat,
  output logic    push,
  output qent_t   push_data
);

  logic                     held;
  logic [COORD_W-1:0]       col;
  logic [COORD_W-1:0]       row;
  logic [COORD_W+STEP_W-1:0] prod_re;
  logic [COORD_W+STEP_W-1:0] prod_im;
  logic [COORD_W-1:0]       col_used;
  logic [COORD_W-1:0]       row_used;
  logic signed [63:0]       sum_re;
  logic signed [63:0]       sum_im;

  // drop coordinate bits above COORD_WIDTH
  always_comb begin
    for (int i = 0; i < COORD_W; i++) begin
      col_used[i] = req.col[i] & (i < COORD_WIDTH);
      row_used[i] = req.row[i] & (i < COORD_WIDTH);
    end
  end

  assign busy = held;
  assign push = held & ~q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !held) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !held) begin
      col     <= col_used;
      row     <= row_used;
      prod_re <= (COORD_W+STEP_W)'(col_used) * (COORD_W+STEP_W)'(cfg.step_re);
      prod_im <= (COORD_W+STEP_W)'(row_used) * (COORD_W+STEP_W)'(cfg.step_im);
    end
  end

  assign sum_re = 64'(cfg.origin_re) + 64'(prod_re);
  assign sum_im = 64'(cfg.origin_im) + 64'(prod_im);

  always_comb begin
    push_data.col = col;
    push_data.row = row;
    push_data.cr  = sat32(sum_re);
    push_data.ci  = sat32(sum_im);
  end

endmodule

FILE: rtl/bse_queue.sv
module bse_queue import bse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qent_t   push_data,
  input  logic    pop,
  output qent_t   head,
  output q_stat_t q_stat
);

  qent_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign q_stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/bse_core.sv
module bse_core import bse_pkg::*; #(
  parameter int FRAC_BITS = 25
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  qent_t   head,
  input  q_stat_t q_stat,
  output logic    pop,
  output logic    done,
  output res_t    result
);

  localparam logic [63:0] LIMIT = 64'd4 << FRAC_BITS;

  core_state_t state;
  core_state_t state_next;

  logic [COORD_W-1:0]      col;
  logic [COORD_W-1:0]      row;
  logic signed [VAL_W-1:0] cr;
  logic signed [VAL_W-1:0] ci;
  logic signed [VAL_W-1:0] zr;
  logic signed [VAL_W-1:0] zi;
  logic [VAL_W-1:0]        ar;
  logic [VAL_W-1:0]        ai;
  logic [63:0]             psr;
  logic [63:0]             psi;
  logic [63:0]             pcx;
  logic [ITER_W-1:0]       n;

  logic [63:0]             sr;
  logic [63:0]             si;
  logic [63:0]             cross_term;
  logic                    escaped;
  logic                    at_limit;
  logic signed [VAL_W-1:0] zr_next;
  logic signed [VAL_W-1:0] zi_next;

  always_comb begin
    sr         = psr >> FRAC_BITS;
    si         = psi >> FRAC_BITS;
    cross_term = pcx >> (FRAC_BITS - 1);
    escaped    = (sr + si) >= LIMIT;
    at_limit   = (n >= cfg.max_iter);
    zr_next    = sat32(signed'(sr) - signed'(si) - 64'(cr));
    zi_next    = sat32(signed'(cross_term) + 64'(ci));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_stat.empty) state_next = S_MAG;
      S_MAG:  state_next = at_limit ? S_DONE : S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = escaped ? S_DONE : S_MAG;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    done = 1'b0;
    case (state)
      S_IDLE:  pop  = ~q_stat.empty;
      S_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col <= head.col;
        row <= head.row;
        cr  <= head.cr;
        ci  <= head.ci;
        zr  <= cfg.start_re;
        zi  <= cfg.start_im;
        n   <= '0;
      end
      S_MAG: begin
        ar <= mag32(zr);
        ai <= mag32(zi);
      end
      S_MUL: begin
        psr <= 64'(ar) * 64'(ar);
        psi <= 64'(ai) * 64'(ai);
        pcx <= 64'(ai) * 64'(ar);
      end
      S_UPD: begin
        if (!escaped) begin
          zr <= zr_next;
          zi <= zi_next;
          n  <= n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.col_out    = col;
    result.row_out    = row;
    result.iter_count = n;
  end

endmodule

FILE: rtl/burning_ship_escape_time_unit.sv
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        req    (col, row)
// result    out        done, one cycle      result (col_out, row_out, iter_count)
// config    in         cfg_we               cfg_index, cfg_data
//
// A request is held in the mapping stage until the queue has room, then waits in a
// two-entry queue. Each iteration of the engine steps through magnitude, squaring
// products and update; a pixel ends when z escapes or max_iter is hit.
// Reset clears the queue and engine and loads the default view into the registers.
// The receiver cannot stall; busy is high the cycle after each accept and stays
// high while the queue is full.
module burning_ship_escape_time_unit import bse_pkg::*; #(
  parameter int COORD_WIDTH = 10,
  parameter int FRAC_BITS   = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  req_t                 req,
  output logic                 busy,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  cfg_t    cfg;
  logic    push;
  qent_t   push_data;
  logic    pop;
  qent_t   head;
  q_stat_t q_stat;

  // Register file: keep only each register's own width, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_re <= RST_ORIGIN_RE;
      cfg.origin_im <= RST_ORIGIN_IM;
      cfg.step_re   <= RST_STEP_RE;
      cfg.step_im   <= RST_STEP_IM;
      cfg.max_iter  <= RST_MAX_ITER;
      cfg.start_re  <= RST_START_RE;
      cfg.start_im  <= RST_START_IM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_RE: cfg.origin_re <= cfg_data;
        CFG_ORIGIN_IM: cfg.origin_im <= cfg_data;
        CFG_STEP_RE:   cfg.step_re   <= cfg_data[STEP_W-1:0];
        CFG_STEP_IM:   cfg.step_im   <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER:  cfg.max_iter  <= cfg_data[ITER_W-1:0];
        CFG_START_RE:  cfg.start_re  <= cfg_data;
        CFG_START_IM:  cfg.start_im  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: map the pixel to c and hand it to the queue.
  bse_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  // Queue: decouple mapping from the iteration loop.
  bse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: run the escape-time loop and strobe the result.
  bse_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

FILE: rtl/bse_checker.sv
module bse_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("mapping stage not held after accept");

  a_reset_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_reset_busy: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

endmodule

bind burning_ship_escape_time_unit bse_checker u_bse_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

FILE: test/burning_ship_escape_time_unit_tb.sv
`timescale 1ns / 100ps

module burning_ship_escape_time_unit_tb;
  import bse_pkg::*;

  localparam int FRAC = 25;
  localparam int ONE_Q = 1 << FRAC;
  // index 7 is not decoded by the block; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_PCT = 17;
  localparam int SETTLE_CYCLES = 4;
  // longest pixel: a full run at max_iter 1023, plus pipeline slack
  localparam int TAIL_CYCLES = 3 * 1023 + 40;
  localparam int PIXELS_PER_VIEW = 140;
  localparam int RANDOM_VIEWS = 12;
  // this view runs with the sender never idling
  localparam int QUIET_VIEW = 5;

  typedef enum logic [1:0] {
    JOB_PIXEL,
    JOB_WRITE,
    JOB_FLUSH
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    req_t                 px;
    logic                 gap_ok;
    logic [CFG_IDX_W-1:0] idx;
    logic [VAL_W-1:0]     data;
  } job_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  req_t                 req = '0;
  logic                 busy;
  logic                 done;
  res_t                 result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  burning_ship_escape_time_unit #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Own copy of the view registers, tracked from the writes seen on the port.
  logic signed [VAL_W-1:0] view_origin_re = RST_ORIGIN_RE;
  logic signed [VAL_W-1:0] view_origin_im = RST_ORIGIN_IM;
  logic [STEP_W-1:0]       view_step_re   = RST_STEP_RE;
  logic [STEP_W-1:0]       view_step_im   = RST_STEP_IM;
  logic [ITER_W-1:0]       view_max_iter  = RST_MAX_ITER;
  logic signed [VAL_W-1:0] view_start_re  = RST_START_RE;
  logic signed [VAL_W-1:0] view_start_im  = RST_START_IM;

  job_t job_q[$];          // pending pixels, register writes and flush points
  res_t predicted[$];      // escape results owed by the block, oldest first

  logic took_req  = 1'b0;  // request accepted at the last rising edge
  logic feed_done = 1'b0;
  int   settle_left = 0;
  int   plan_iter = int'(RST_MAX_ITER);
  int   cycle_budget = 0;
  int   cycle_limit = 0;
  int   cycle_cnt = 0;
  int   fail_cnt = 0;
  int   checked_cnt = 0;
  int   zero_cnt = 0;
  int   capped_cnt = 0;
  int   write_cnt = 0;
  int   flush_cnt = 0;

  function automatic logic signed [VAL_W-1:0] clamp_s32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [63:0] abs_q(input logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Map the pixel into the plane and run the burning-ship rule on the current view.
  function automatic res_t predict_escape(input req_t px);
    logic [63:0]        ar;
    logic [63:0]        ai;
    logic [63:0]        sr;
    logic [63:0]        si;
    logic [63:0]        cross_q;
    logic signed [63:0] base;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] zr;
    logic signed [63:0] zi;
    logic               escaped;
    int                 n;
    res_t               r;
    base = view_origin_re;
    cr = clamp_s32(base + $signed(64'(px.col) * 64'(view_step_re)));
    base = view_origin_im;
    ci = clamp_s32(base + $signed(64'(px.row) * 64'(view_step_im)));
    zr = view_start_re;
    zi = view_start_im;
    n = 0;
    escaped = 1'b0;
    while (n < int'(view_max_iter) && !escaped) begin
      ar = abs_q(zr);
      ai = abs_q(zi);
      sr = (ar * ar) >> FRAC;
      si = (ai * ai) >> FRAC;
      // escape test comes before the step, so a start outside radius 2 gives zero
      if (sr + si >= (64'd4 << FRAC)) begin
        escaped = 1'b1;
      end else begin
        cross_q = (ai * ar) >> (FRAC - 1);
        zr = clamp_s32($signed(sr) - $signed(si) - cr);
        zi = clamp_s32($signed(cross_q) + ci);
        n++;
      end
    end
    r.col_out    = px.col;
    r.row_out    = px.row;
    r.iter_count = ITER_W'(n);
    return r;
  endfunction

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    job_t j;
    j = '0;
    j.kind = JOB_WRITE;
    j.idx  = idx;
    j.data = data;
    job_q.push_back(j);
    if (idx == CFG_MAX_ITER) begin
      plan_iter = int'(data[ITER_W-1:0]);
    end
    cycle_budget += 2;
  endtask

  task automatic add_pixel(input int c, input int r, input logic gap_ok);
    job_t j;
    j = '0;
    j.kind   = JOB_PIXEL;
    j.px.col = COORD_W'(c);
    j.px.row = COORD_W'(r);
    j.gap_ok = gap_ok;
    job_q.push_back(j);
    // worst case: the pixel runs to the limit, plus queue, gap and done cycles
    cycle_budget += 3 * plan_iter + 12;
  endtask

  task automatic add_flush();
    job_t j;
    j = '0;
    j.kind = JOB_FLUSH;
    job_q.push_back(j);
    cycle_budget += SETTLE_CYCLES + 8;
  endtask

  // Drain the block, then load a fresh view. Noisy views take any origin, step
  // and start values; others aim at the region where escape counts spread out.
  task automatic add_random_view(input bit noisy);
    int               ore;
    int               oim;
    int               sre;
    int               sim;
    int               zr0;
    int               zi0;
    int               it;
    int               sel;
    logic [VAL_W-1:0] junk;
    add_flush();
    junk = $urandom();
    if (noisy) begin
      add_write(CFG_ORIGIN_RE, $urandom());
      add_write(CFG_ORIGIN_IM, $urandom());
      add_write(CFG_STEP_RE, $urandom());
      add_write(CFG_STEP_IM, $urandom());
      add_write(CFG_START_RE, $urandom());
      add_write(CFG_START_IM, $urandom());
      it = $urandom_range(1, 64);
    end else begin
      ore = $urandom_range(0, ONE_Q);
      ore = ore - 2 * ONE_Q;
      oim = $urandom_range(0, ONE_Q);
      oim = oim - 3 * ONE_Q / 2;
      sre = $urandom_range(ONE_Q / 1024, ONE_Q / 200);
      sim = $urandom_range(ONE_Q / 1024, ONE_Q / 200);
      zr0 = 0;
      zi0 = 0;
      if ($urandom_range(0, 2) == 0) begin
        zr0 = $urandom_range(0, ONE_Q / 2);
        zr0 = zr0 - ONE_Q / 4;
        zi0 = $urandom_range(0, ONE_Q / 2);
        zi0 = zi0 - ONE_Q / 4;
      end
      add_write(CFG_ORIGIN_RE, VAL_W'(ore));
      add_write(CFG_ORIGIN_IM, VAL_W'(oim));
      // the top data bit is not part of a step register; toggle it freely
      add_write(CFG_STEP_RE, {junk[VAL_W-1], STEP_W'(sre)});
      add_write(CFG_STEP_IM, {junk[VAL_W-2], STEP_W'(sim)});
      add_write(CFG_START_RE, VAL_W'(zr0));
      add_write(CFG_START_IM, VAL_W'(zi0));
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        it = $urandom_range(0, 3);
      end else if (sel == 9) begin
        it = $urandom_range(65, 128);
      end else begin
        it = $urandom_range(4, 64);
      end
    end
    add_write(CFG_MAX_ITER, {junk[VAL_W-1:ITER_W], ITER_W'(it)});
    if ($urandom_range(0, 2) == 0) begin
      add_write(CFG_UNUSED, $urandom());
    end
  endtask

  // Driver: present requests, register writes and drain points at the falling edge.
  always @(negedge clk) begin
    job_t job;
    logic nxt_start;
    logic nxt_we;
    nxt_start = 1'b0;
    nxt_we    = 1'b0;
    if (!rst) begin
      if (start && !took_req) begin
        // hold the request until the block takes it
        nxt_start = 1'b1;
      end else if (settle_left > 0) begin
        settle_left--;
      end else if (job_q.size() == 0) begin
        feed_done = 1'b1;
      end else begin
        job = job_q[0];
        case (job.kind)
          JOB_PIXEL: begin
            if (!(job.gap_ok && $urandom_range(0, 99) < IDLE_PCT)) begin
              req <= job.px;
              nxt_start = 1'b1;
              job = job_q.pop_front();
            end
          end
          JOB_WRITE: begin
            // writes only follow a drain point or reset, so the block is idle here
            cfg_index <= job.idx;
            cfg_data  <= job.data;
            nxt_we = 1'b1;
            job = job_q.pop_front();
          end
          JOB_FLUSH: begin
            // stall the sender until every owed result is back, then let it settle
            if (predicted.size() == 0) begin
              settle_left = SETTLE_CYCLES;
              flush_cnt++;
              job = job_q.pop_front();
            end
          end
          default: begin
            job = job_q.pop_front();
          end
        endcase
      end
    end
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  // Monitor: sample the ports at the rising edge, predict on accept, check on done.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      took_req = 1'b0;
    end else begin
      took_req = start && !busy;
      if (took_req) begin
        want = predict_escape(req);
        predicted.push_back(want);
        if (want.iter_count == '0) begin
          zero_cnt++;
        end else if (want.iter_count == view_max_iter) begin
          capped_cnt++;
        end
      end
      if (cfg_we) begin
        write_cnt++;
        // drop bits above each register's width; ignore undecoded indexes
        case (cfg_index)
          CFG_ORIGIN_RE: view_origin_re = cfg_data;
          CFG_ORIGIN_IM: view_origin_im = cfg_data;
          CFG_STEP_RE:   view_step_re   = cfg_data[STEP_W-1:0];
          CFG_STEP_IM:   view_step_im   = cfg_data[STEP_W-1:0];
          CFG_MAX_ITER:  view_max_iter  = cfg_data[ITER_W-1:0];
          CFG_START_RE:  view_start_re  = cfg_data;
          CFG_START_IM:  view_start_im  = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (predicted.size() == 0) begin
          $error("result with no request pending: col_out %0d row_out %0d iter_count %0d",
                 result.col_out, result.row_out, result.iter_count);
          fail_cnt++;
        end else begin
          want = predicted.pop_front();
          checked_cnt++;
          if (result.col_out !== want.col_out) begin
            $error("col_out: expected %0d, got %0d", want.col_out, result.col_out);
            fail_cnt++;
          end
          if (result.row_out !== want.row_out) begin
            $error("row_out: expected %0d, got %0d", want.row_out, result.row_out);
            fail_cnt++;
          end
          if (result.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, got %0d (pixel %0d,%0d)",
                   want.iter_count, result.iter_count, want.col_out, want.row_out);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles against a limit derived from the stimulus.
  initial begin
    @(posedge clk);
    while (cycle_cnt < cycle_limit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, predicted.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int c;
    int r;

    // Reset view: corners of the coordinate space and a spread of interior pixels.
    add_pixel(0, 0, 1'b1);
    add_pixel(1023, 1023, 1'b1);
    add_pixel(0, 1023, 1'b1);
    add_pixel(1023, 0, 1'b1);
    add_pixel(400, 400, 1'b1);
    add_pixel(200, 700, 1'b1);
    add_pixel(700, 300, 1'b1);
    add_pixel(512, 512, 1'b1);

    // Zero limit, with junk above the max_iter field.
    add_flush();
    add_write(CFG_MAX_ITER, 32'hFFFF_FC00);
    add_pixel(5, 9, 1'b1);
    add_pixel(1023, 0, 1'b1);

    // Never escapes: c pinned to zero at the full limit. The step writes carry at most
    // the bit above the register, so the steps read back as zero.
    add_flush();
    add_write(CFG_UNUSED, 32'hFFFF_FFFF);
    add_write(CFG_MAX_ITER, 32'hA5A5_A7FF);
    add_write(CFG_ORIGIN_RE, 32'h0000_0000);
    add_write(CFG_ORIGIN_IM, 32'h0000_0000);
    add_write(CFG_STEP_RE, 32'h8000_0000);
    add_write(CFG_STEP_IM, 32'h0000_0000);
    add_write(CFG_START_RE, 32'h0000_0000);
    add_write(CFG_START_IM, 32'h0000_0000);
    add_pixel(0, 0, 1'b1);
    add_pixel(1023, 1023, 1'b1);

    // Escape at start: |z| exactly 2, then the most extreme start values.
    add_flush();
    add_write(CFG_START_RE, VAL_W'(2 * ONE_Q));
    add_pixel(3, 3, 1'b1);
    add_pixel(1023, 512, 1'b1);
    add_flush();
    add_write(CFG_START_RE, 32'h8000_0000);
    add_write(CFG_START_IM, 32'h7FFF_FFFF);
    add_pixel(77, 901, 1'b1);

    // Saturation: extreme origins and steps push both mapping and update to the rails.
    add_flush();
    add_write(CFG_ORIGIN_RE, 32'h8000_0000);
    add_write(CFG_ORIGIN_IM, 32'h7FFF_FFFF);
    add_write(CFG_STEP_RE, 32'h7FFF_FFFF);
    add_write(CFG_STEP_IM, 32'hFFFF_FFFF);
    add_write(CFG_START_RE, VAL_W'(3 * ONE_Q / 2));
    add_write(CFG_START_IM, VAL_W'(ONE_Q));
    add_write(CFG_MAX_ITER, 32'h0000_0008);
    add_pixel(0, 0, 1'b1);
    add_pixel(1023, 1023, 1'b1);
    add_pixel(0, 1023, 1'b1);
    add_pixel(1023, 0, 1'b1);
    add_pixel(1, 1, 1'b1);

    // Random views, each separated by a drain point; every fourth one is noise.
    for (int v = 0; v < RANDOM_VIEWS; v++) begin
      add_random_view((v % 4) == 3);
      for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
        c = $urandom_range(0, 1023);
        r = $urandom_range(0, 1023);
        if ($urandom_range(0, 99) < 12) begin
          c = $urandom_range(0, 1) * 1023;
        end
        if ($urandom_range(0, 99) < 12) begin
          r = $urandom_range(0, 1) * 1023;
        end
        add_pixel(c, r, v != QUIET_VIEW);
      end
    end

    cycle_limit = 4 * cycle_budget + 20000 + TAIL_CYCLES;

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (feed_done);
    while (predicted.size() != 0) begin
      @(negedge clk);
    end
    // keep watching for stray results for one full worst-case pixel
    repeat (TAIL_CYCLES) @(negedge clk);
    if (predicted.size() != 0) begin
      $error("%0d expected results never arrived", predicted.size());
      fail_cnt += predicted.size();
    end

    $display("Checked %0d pixel results over %0d drain points and %0d register writes.",
             checked_cnt, flush_cnt, write_cnt);
    $display("%0d pixels finished with no iteration, %0d ran to the iteration limit.",
             zero_cnt, capped_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bse_pkg.sv
rtl/bse_front.sv
rtl/bse_queue.sv
rtl/bse_core.sv
rtl/burning_ship_escape_time_unit.sv
rtl/bse_checker.sv
test/burning_ship_escape_time_unit_tb.sv
